>>> rtl/core/tte_pkg.sv
// Shared types, constants and helper function of the two-tap echo block.
package tte_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = 16;
	localparam int DELAY_BITS  = 12;
	localparam int CFG_BITS    = 16;
	localparam int TAP_W       = 18;
	localparam int PROD_W      = 36;
	localparam int SUM_W       = 20;

	localparam logic [GAIN_BITS:0]  GAIN_ONE = 17'd32768;
	localparam logic signed [PROD_W-1:0] HALF_LSB = 36'sd16384;
	localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 20'sd32767;
	localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -20'sd32768;

	typedef enum logic {
		CFG_ECHO_GAIN    = 1'b0,
		CFG_DELAY_FRAMES = 1'b1
	} cfg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_TAP1  = 5'b00010,
		ST_TAP2A = 5'b00100,
		ST_TAP2B = 5'b01000,
		ST_SUM   = 5'b10000
	} state_t;

	typedef enum logic {
		MUL_HIST = 1'b0,
		MUL_TAP  = 1'b1
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		logic     rd_p2;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     cap_t1;
		logic     load_out;
	} cmd_t;

	// floor((v + 2^14) / 2^15)
	function automatic logic signed [TAP_W-1:0] round_q15(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] s;
		s = v + HALF_LSB;
		return s[TAP_W+14:15];
	endfunction

endpackage

>>> rtl/core/tte_if.sv
// Stream interfaces for input frames and result frames.
interface tte_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tte_pkg::SAMPLE_BITS-1:0] in_left;
	logic signed [tte_pkg::SAMPLE_BITS-1:0] in_right;
	logic                                start_of_buffer;

	modport source (output valid, output in_left, output in_right, output start_of_buffer,
		input ready);
	modport sink (input valid, input in_left, input in_right, input start_of_buffer,
		output ready);
endinterface

interface tte_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tte_pkg::SAMPLE_BITS-1:0] out_left;
	logic signed [tte_pkg::SAMPLE_BITS-1:0] out_right;
	logic                                saturated;

	modport source (output valid, output out_left, output out_right, output saturated,
		input ready);
	modport sink (input valid, input out_left, input out_right, input saturated,
		output ready);
endinterface

>>> rtl/core/tte_ctrl.sv
// Sequencer for one frame: history reads, tap multiplies, sum and output register.
module tte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tte_pkg::cmd_t cmd
);

	tte_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mul_sel  = tte_pkg::MUL_HIST;
		case (state_q)
			tte_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = tte_pkg::ST_TAP1;
				end
			end
			tte_pkg::ST_TAP1: begin
				cmd.rd_p2  = 1'b1;
				cmd.mul_en = 1'b1;
				state_d    = tte_pkg::ST_TAP2A;
			end
			tte_pkg::ST_TAP2A: begin
				cmd.cap_t1 = 1'b1;
				cmd.mul_en = 1'b1;
				state_d    = tte_pkg::ST_TAP2B;
			end
			tte_pkg::ST_TAP2B: begin
				cmd.mul_sel = tte_pkg::MUL_TAP;
				cmd.mul_en  = 1'b1;
				state_d     = tte_pkg::ST_SUM;
			end
			tte_pkg::ST_SUM: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = tte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tte_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tte_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/tte_datapath.sv
// History memory, pointers, configuration registers, tap multipliers and output register.
module tte_datapath #(
	parameter int MAX_DELAY = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [tte_pkg::CFG_BITS-1:0]           cfg_data,
	input  tte_pkg::cmd_t                          cmd,
	input  logic signed [tte_pkg::SAMPLE_BITS-1:0] in_left,
	input  logic signed [tte_pkg::SAMPLE_BITS-1:0] in_right,
	input  logic                                   start_of_buffer,
	output logic signed [tte_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [tte_pkg::SAMPLE_BITS-1:0] out_right,
	output logic                                   saturated
);

	localparam int SB    = tte_pkg::SAMPLE_BITS;
	localparam int DEPTH = 2 * MAX_DELAY;
	localparam int PW    = $clog2(DEPTH);
	localparam int EW    = ((PW > tte_pkg::DELAY_BITS) ? PW : tte_pkg::DELAY_BITS) + 1;
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);
	localparam logic [EW-1:0] DMAX_E  = EW'(MAX_DELAY - 1);

	// configuration
	logic [tte_pkg::GAIN_BITS-1:0]  gain_q;
	logic [tte_pkg::DELAY_BITS-1:0] delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= tte_pkg::GAIN_ONE[tte_pkg::GAIN_BITS-1:0];
			delay_q <= tte_pkg::DELAY_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tte_pkg::CFG_ECHO_GAIN:    gain_q  <= cfg_data[tte_pkg::GAIN_BITS-1:0];
				tte_pkg::CFG_DELAY_FRAMES: delay_q <= cfg_data[tte_pkg::DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [tte_pkg::GAIN_BITS:0] g;
	logic [EW-1:0]               dl_e, d_e;
	logic [PW-1:0]               d, d2;

	always_comb begin
		g    = ({1'b0, gain_q} > tte_pkg::GAIN_ONE) ? tte_pkg::GAIN_ONE : {1'b0, gain_q};
		dl_e = EW'(delay_q);
		if (dl_e == '0) begin
			d_e = EW'(1);
		end else if (dl_e > DMAX_E) begin
			d_e = DMAX_E;
		end else begin
			d_e = dl_e;
		end
		d  = d_e[PW-1:0];
		d2 = d << 1;
	end

	// pointers and tap eligibility
	logic [PW-1:0] wp_q, wa_q, p2_q, cnt_q;
	logic [PW-1:0] p1, p2, cnt_eff;
	logic          use1_q, use2_q;

	always_comb begin
		cnt_eff = start_of_buffer ? '0 : cnt_q;
		p1      = (wp_q >= d)  ? (wp_q - d)  : (wp_q + DEPTH_P - d);
		p2      = (wp_q >= d2) ? (wp_q - d2) : (wp_q + DEPTH_P - d2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.accept) begin
			wp_q  <= (wp_q == LAST_P) ? '0 : wp_q + PW'(1);
			cnt_q <= (cnt_eff < d2) ? cnt_eff + PW'(1) : d2;
		end
	end

	logic signed [SB-1:0] x_q [2];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			wa_q    <= wp_q;
			p2_q    <= p2;
			use1_q  <= cnt_eff >= d;
			use2_q  <= cnt_eff >= d2;
			x_q[0]  <= in_left;
			x_q[1]  <= in_right;
		end
	end

	// history memory: one write port, one registered read port
	logic [2*SB-1:0] mem [DEPTH];
	logic [2*SB-1:0] rd_data_q;
	logic [PW-1:0]   rd_addr;

	assign rd_addr = cmd.rd_p2 ? p2_q : p1;

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.rd_p2) begin
			mem[wa_q] <= {x_q[1], x_q[0]};
		end
	end

	// per-channel multiplier, reused for all three products
	logic signed [tte_pkg::PROD_W-1:0]   prod_q [2];
	logic signed [tte_pkg::TAP_W-1:0]    t1_q   [2];
	logic signed [tte_pkg::TAP_W-1:0]    mul_a  [2];
	logic signed [tte_pkg::SUM_W-1:0]    y      [2];
	logic signed [tte_pkg::SUM_W-1:0]    ys     [2];
	logic                                clip   [2];
	logic signed [tte_pkg::GAIN_BITS+1:0] g_s;

	assign g_s = $signed({1'b0, g});

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (cmd.mul_sel == tte_pkg::MUL_TAP) begin
				mul_a[c] = tte_pkg::round_q15(prod_q[c]);
			end else begin
				mul_a[c] = tte_pkg::TAP_W'($signed(rd_data_q[c*SB +: SB]));
			end
			y[c] = tte_pkg::SUM_W'(x_q[c])
				+ (use1_q ? tte_pkg::SUM_W'(t1_q[c]) : '0)
				+ (use2_q ? tte_pkg::SUM_W'(tte_pkg::round_q15(prod_q[c])) : '0);
			if (y[c] > tte_pkg::SAMPLE_MAX) begin
				ys[c]   = tte_pkg::SAMPLE_MAX;
				clip[c] = 1'b1;
			end else if (y[c] < tte_pkg::SAMPLE_MIN) begin
				ys[c]   = tte_pkg::SAMPLE_MIN;
				clip[c] = 1'b1;
			end else begin
				ys[c]   = y[c];
				clip[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 2; c++) begin
			if (cmd.mul_en) begin
				prod_q[c] <= tte_pkg::PROD_W'(mul_a[c]) * tte_pkg::PROD_W'(g_s);
			end
			if (cmd.cap_t1) begin
				t1_q[c] <= tte_pkg::round_q15(prod_q[c]);
			end
		end
		if (cmd.load_out) begin
			out_left  <= ys[0][SB-1:0];
			out_right <= ys[1][SB-1:0];
			saturated <= clip[0] | clip[1];
		end
	end

endmodule

>>> rtl/core/two_tap_echo_top.sv
// Top level of the two-tap stereo echo.
//
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     in_left, in_right, start_of_buffer
//  out_ch   out  valid/ready     out_left, out_right, saturated
//  cfg      in   cfg_we          cfg_index, cfg_data
//
// A frame runs through the states in order: the transfer edge reads the first tap,
// the next edge reads the second tap, writes the frame and starts three multiplies
// on one multiplier per channel (first tap, second tap, second tap again), and the
// sum step then loads the saturated sum. A new input is taken only once it is loaded.
// The output register stalls the sum step only while it still holds an untaken result.
// Reset clears the write pointer and count and sets unity gain and a delay of one frame; the history is not cleared.
module two_tap_echo_top #(
	parameter int MAX_DELAY = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [tte_pkg::CFG_BITS-1:0] cfg_data,
	tte_in_if.sink                       in_ch,
	tte_out_if.source                    out_ch
);

	tte_pkg::cmd_t cmd;

	tte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	tte_datapath #(
		.MAX_DELAY (MAX_DELAY)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.in_left         (in_ch.in_left),
		.in_right        (in_ch.in_right),
		.start_of_buffer (in_ch.start_of_buffer),
		.out_left        (out_ch.out_left),
		.out_right       (out_ch.out_right),
		.saturated       (out_ch.saturated)
	);

	a_accept_is_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept == (in_ch.valid && in_ch.ready))
		else $error("accept command differs from input transfer");

	a_read_p2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.rd_p2 && !in_ch.ready)
		else $error("second history read did not follow input transfer");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_ch.valid)
		else $error("loaded result not presented");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.rd_p2, cmd.cap_t1, cmd.load_out}))
		else $error("overlapping sequencer commands");

endmodule
